// ----- rtl/imp_pkg.sv -----
// ----------------------------------------------------------------------------
// imp_pkg
// Shared types and constants of the indexed max-priority table: request
// codes, memory operation codes and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package imp_pkg;

   localparam int KEY_W     = 6;
   localparam int PRIO_IN_W = 12;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_INCREASE = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_QUERY    = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_INSERT,
      MEM_REMOVE,
      MEM_READ_KEY,
      MEM_READ_IDX,
      MEM_INC_WRITE
   } mem_op_type;

   typedef struct packed {
      logic       latch_req;
      mem_op_type mem_op;
      logic       idx_clear;
      logic       idx_inc;
      logic       scan_init;
      logic       scan_cmp;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      req_op_type req_op;
      logic       key_ok;
      logic       idx_last;
      logic       rsp_free;
   } sts_type;

endpackage

// ----- rtl/imp_if.sv -----
// ----------------------------------------------------------------------------
// imp_req_if / imp_rsp_if
// Valid/ready channels of the indexed max-priority table.
// ----------------------------------------------------------------------------
interface imp_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic [imp_pkg::KEY_W-1:0]       key_id;
   logic [imp_pkg::PRIO_IN_W-1:0]   initial_priority;
   logic [imp_pkg::PRIO_IN_W-1:0]   priority_increase;

   modport source (output valid, req_type, key_id, initial_priority, priority_increase,
                   input ready);
   modport sink   (input valid, req_type, key_id, initial_priority, priority_increase,
                   output ready);
endinterface

interface imp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [imp_pkg::KEY_W-1:0] top_key;
   logic                      table_empty;
   logic                      stamp_exhausted;

   modport source (output valid, top_key, table_empty, stamp_exhausted, input ready);
   modport sink   (input valid, top_key, table_empty, stamp_exhausted, output ready);
endinterface

// ----- rtl/imp_dp.sv -----
// ----------------------------------------------------------------------------
// imp_dp
// Datapath: request registers, entry memory, arrival stamp counter, scan
// comparator and result register.
// ----------------------------------------------------------------------------
module imp_dp #(
   parameter int NUM_KEYS      = 64,
   parameter int PRIORITY_BITS = 12,
   parameter int STAMP_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  imp_pkg::cmd_type                cmd,
   output imp_pkg::sts_type                sts,
   input  logic [1:0]                      req_type,
   input  logic [imp_pkg::KEY_W-1:0]       key_id,
   input  logic [imp_pkg::PRIO_IN_W-1:0]   initial_priority,
   input  logic [imp_pkg::PRIO_IN_W-1:0]   priority_increase,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [imp_pkg::KEY_W-1:0]       top_key,
   output logic                            table_empty,
   output logic                            stamp_exhausted
);

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SUM_W = ((PRIORITY_BITS > imp_pkg::PRIO_IN_W) ?
                           PRIORITY_BITS : imp_pkg::PRIO_IN_W) + 1;
   localparam logic [PRIORITY_BITS-1:0] PRIO_MAX  = '1;
   localparam logic [STAMP_BITS-1:0]    STAMP_MAX = '1;

   typedef struct packed {
      logic                     valid;
      logic [PRIORITY_BITS-1:0] prio;
      logic [STAMP_BITS-1:0]    stamp;
   } entry_type;

   entry_type mem [NUM_KEYS];
   entry_type rd_data_ff;
   entry_type mem_wdata;
   logic      mem_we;
   logic      mem_re;
   logic [IDX_W-1:0] mem_addr;

   imp_pkg::req_op_type           req_op_ff;
   logic [imp_pkg::KEY_W-1:0]     key_ff;
   logic [imp_pkg::PRIO_IN_W-1:0] init_ff;
   logic [imp_pkg::PRIO_IN_W-1:0] inc_ff;

   logic [STAMP_BITS-1:0]    next_stamp_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic [STAMP_BITS-1:0]    best_stamp_ff;

   logic                      rsp_valid_ff;
   logic [imp_pkg::KEY_W-1:0] top_key_ff;
   logic                      empty_ff;
   logic                      exhausted_ff;

   logic [IDX_W-1:0]         key_idx;
   logic [SUM_W-1:0]         init_ext;
   logic [SUM_W-1:0]         inc_sum;
   logic [PRIORITY_BITS-1:0] init_p;
   logic [PRIORITY_BITS-1:0] inc_p;
   logic                     better;

   assign key_idx  = IDX_W'(key_ff);
   assign init_ext = SUM_W'(init_ff);
   assign inc_sum  = SUM_W'(rd_data_ff.prio) + SUM_W'(inc_ff);
   assign init_p   = (init_ext > SUM_W'(PRIO_MAX)) ? PRIO_MAX : init_ext[PRIORITY_BITS-1:0];
   assign inc_p    = (inc_sum > SUM_W'(PRIO_MAX)) ? PRIO_MAX : inc_sum[PRIORITY_BITS-1:0];

   assign better = rd_data_ff.valid &&
                   (!found_ff || (rd_data_ff.prio > best_prio_ff) ||
                    ((rd_data_ff.prio == best_prio_ff) && (rd_data_ff.stamp < best_stamp_ff)));

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = key_idx;
      mem_wdata = '0;
      case (cmd.mem_op)
         imp_pkg::MEM_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = idx_ff;
         end
         imp_pkg::MEM_INSERT: begin
            mem_we    = 1'b1;
            mem_wdata = '{valid: 1'b1, prio: init_p, stamp: next_stamp_ff};
         end
         imp_pkg::MEM_REMOVE: begin
            mem_we = 1'b1;
         end
         imp_pkg::MEM_READ_KEY: begin
            mem_re = 1'b1;
         end
         imp_pkg::MEM_READ_IDX: begin
            mem_re   = 1'b1;
            mem_addr = idx_ff;
         end
         imp_pkg::MEM_INC_WRITE: begin
            mem_we    = rd_data_ff.valid;
            mem_wdata = '{valid: 1'b1, prio: inc_p, stamp: rd_data_ff.stamp};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_op_ff <= imp_pkg::req_op_type'(req_type);
         key_ff    <= key_id;
         init_ff   <= initial_priority;
         inc_ff    <= priority_increase;
      end
      if (cmd.mem_op == imp_pkg::MEM_READ_IDX) begin
         rd_idx_ff <= idx_ff;
      end
      if (cmd.scan_cmp && better) begin
         best_idx_ff   <= rd_idx_ff;
         best_prio_ff  <= rd_data_ff.prio;
         best_stamp_ff <= rd_data_ff.stamp;
      end
      if (cmd.load_rsp) begin
         top_key_ff   <= found_ff ? imp_pkg::KEY_W'(best_idx_ff) : '0;
         empty_ff     <= !found_ff;
         exhausted_ff <= (next_stamp_ff == STAMP_MAX);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         next_stamp_ff <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if ((cmd.mem_op == imp_pkg::MEM_INSERT) && (next_stamp_ff != STAMP_MAX)) begin
            next_stamp_ff <= next_stamp_ff + 1'b1;
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (cmd.scan_cmp && better) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign sts.req_op   = req_op_ff;
   assign sts.key_ok   = (32'(key_ff) < 32'(NUM_KEYS));
   assign sts.idx_last = (idx_ff == IDX_W'(NUM_KEYS - 1));
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign top_key         = top_key_ff;
   assign table_empty     = empty_ff;
   assign stamp_exhausted = exhausted_ff;

endmodule

// ----- rtl/imp_ctrl.sv -----
// ----------------------------------------------------------------------------
// imp_ctrl
// Controller: clearing pass after reset, request decode, read-modify-write
// for increase and the query scan sequence.
// ----------------------------------------------------------------------------
module imp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output imp_pkg::cmd_type cmd,
   input  imp_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_INC_WRITE,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mem_op    = imp_pkg::MEM_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op = imp_pkg::MEM_CLEAR;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (sts.req_op)
               imp_pkg::OP_INSERT: begin
                  if (sts.key_ok) cmd.mem_op = imp_pkg::MEM_INSERT;
               end
               imp_pkg::OP_INCREASE: begin
                  if (sts.key_ok) begin
                     cmd.mem_op = imp_pkg::MEM_READ_KEY;
                     state_in   = ST_INC_WRITE;
                  end
               end
               imp_pkg::OP_REMOVE: begin
                  if (sts.key_ok) cmd.mem_op = imp_pkg::MEM_REMOVE;
               end
               imp_pkg::OP_QUERY: begin
                  cmd.scan_init = 1'b1;
                  cmd.mem_op    = imp_pkg::MEM_READ_IDX;
                  cmd.idx_inc   = 1'b1;
                  state_in      = ST_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INC_WRITE: begin
            cmd.mem_op = imp_pkg::MEM_INC_WRITE;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.mem_op   = imp_pkg::MEM_READ_IDX;
            cmd.scan_cmp = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_SCAN_TAIL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN_TAIL: begin
            cmd.scan_cmp = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            // hold until the result register is free
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/indexed_max_priority_table.sv -----
// ----------------------------------------------------------------------------
// indexed_max_priority_table
// Table of entries indexed by key id with insert, saturating increase,
// remove and a query for the highest priority entry (earliest arrival, then
// lowest key, wins ties).
//
//   channel   dir   beat contents
//   req_chan  in    req_type, key_id, initial_priority, priority_increase
//   rsp_chan  out   top_key, table_empty, stamp_exhausted (queries only)
//
// Insert and remove each write the entry memory once, increase is a
// read-modify-write on the single entry memory port, and a query makes one
// memory read per entry, compared against the running best.
// After reset a clearing pass zeroes the entry memory;
// req_chan.ready stays low during it.
// A finished query waits while the previous result beat is still held on
// rsp_chan; req_chan.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module indexed_max_priority_table #(
   parameter int NUM_KEYS      = 64,
   parameter int PRIORITY_BITS = 12,
   parameter int STAMP_BITS    = 16
) (
   input logic         clock,
   input logic         reset,
   imp_req_if.sink     req_chan,
   imp_rsp_if.source   rsp_chan
);

   imp_pkg::cmd_type cmd;
   imp_pkg::sts_type sts;

   imp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   imp_dp #(
      .NUM_KEYS      (NUM_KEYS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .STAMP_BITS    (STAMP_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_chan.req_type),
      .key_id            (req_chan.key_id),
      .initial_priority  (req_chan.initial_priority),
      .priority_increase (req_chan.priority_increase),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .top_key           (rsp_chan.top_key),
      .table_empty       (rsp_chan.table_empty),
      .stamp_exhausted   (rsp_chan.stamp_exhausted)
   );

endmodule

// ----- verif/imp_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imp_table_checker
// Watches both channels of the indexed max-priority table. Every request
// beat is applied to a shadow table of valid bits, priorities and arrival
// stamps; a query beat queues the answer that the shadow table gives. Every
// result beat is checked field by field against the oldest queued answer.
// ----------------------------------------------------------------------------
module imp_table_checker (
   input  logic clock,
   input  logic reset,
   imp_req_if   req_chan,
   imp_rsp_if   rsp_chan,
   output int   fail_count,
   output int   answers_due
);

   localparam int NUM_KEYS = 64;
   localparam int PRIO_W   = 12;
   localparam int STAMP_W  = 16;

   typedef struct packed {
      logic [imp_pkg::KEY_W-1:0] top_key;
      logic                      table_empty;
      logic                      stamp_exhausted;
   } top_answer_type;

   logic               shadow_valid [NUM_KEYS];
   logic [PRIO_W-1:0]  shadow_prio  [NUM_KEYS];
   logic [STAMP_W-1:0] shadow_stamp [NUM_KEYS];
   logic [STAMP_W-1:0] stamp_next;
   top_answer_type     answers_queued [$];

   function automatic top_answer_type highest_entry();
      top_answer_type ans;
      logic           found;
      int             best;
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (shadow_valid[i] && (!found || shadow_prio[i] > shadow_prio[best] ||
             (shadow_prio[i] == shadow_prio[best] &&
              shadow_stamp[i] < shadow_stamp[best]))) begin
            best  = i;
            found = 1'b1;
         end
      end
      ans.top_key         = found ? imp_pkg::KEY_W'(best) : '0;
      ans.table_empty     = !found;
      ans.stamp_exhausted = (stamp_next == '1);
      return ans;
   endfunction

   task automatic apply_request(input imp_pkg::req_op_type op,
                                input logic [imp_pkg::KEY_W-1:0] key,
                                input logic [imp_pkg::PRIO_IN_W-1:0] init_p,
                                input logic [imp_pkg::PRIO_IN_W-1:0] inc_p);
      logic [PRIO_W:0] sum;
      case (op)
         imp_pkg::OP_INSERT: begin
            shadow_valid[key] = 1'b1;
            shadow_prio[key]  = init_p;
            shadow_stamp[key] = stamp_next;
            if (stamp_next != '1) stamp_next = stamp_next + 1'b1;
         end
         imp_pkg::OP_INCREASE: begin
            if (shadow_valid[key]) begin
               sum = {1'b0, shadow_prio[key]} + {1'b0, inc_p};
               shadow_prio[key] = sum[PRIO_W] ? '1 : sum[PRIO_W-1:0];
            end
         end
         imp_pkg::OP_REMOVE: shadow_valid[key] = 1'b0;
         imp_pkg::OP_QUERY:  answers_queued.push_back(highest_entry());
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      top_answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_prio[i]  = '0;
            shadow_stamp[i] = '0;
         end
         stamp_next = '0;
         fail_count = 0;
         answers_queued.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answers_queued.size() == 0) begin
               $display("%0t: result beat with no query pending, top_key %0d empty %0b",
                        $time, rsp_chan.top_key, rsp_chan.table_empty);
               fail_count++;
            end else begin
               want = answers_queued.pop_front();
               if (rsp_chan.top_key !== want.top_key) begin
                  $display("%0t: top_key mismatch, expected %0d, actual %0d",
                           $time, want.top_key, rsp_chan.top_key);
                  fail_count++;
               end
               if (rsp_chan.table_empty !== want.table_empty) begin
                  $display("%0t: table_empty mismatch, expected %0b, actual %0b",
                           $time, want.table_empty, rsp_chan.table_empty);
                  fail_count++;
               end
               if (rsp_chan.stamp_exhausted !== want.stamp_exhausted) begin
                  $display("%0t: stamp_exhausted mismatch, expected %0b, actual %0b",
                           $time, want.stamp_exhausted, rsp_chan.stamp_exhausted);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            apply_request(imp_pkg::req_op_type'(req_chan.req_type), req_chan.key_id,
                          req_chan.initial_priority, req_chan.priority_increase);
      end
      answers_due <= answers_queued.size();
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the indexed max-priority table: a directed opening on empty
// tables, ties, re-inserts and saturation, random traffic under several
// idling patterns with a long result stall, a tie decided by arrival order,
// and random traffic after that. Checking is done by imp_table_checker; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES    = 1500;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_seq;
   int   fail_count;
   int   answers_due;

   imp_req_if req_chan ();
   imp_rsp_if rsp_chan ();

   indexed_max_priority_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   imp_table_checker prio_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .fail_count  (fail_count),
      .answers_due (answers_due)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [imp_pkg::PRIO_IN_W-1:0] rnd12();
      return imp_pkg::PRIO_IN_W'($urandom_range(4095));
   endfunction

   function automatic logic [imp_pkg::PRIO_IN_W-1:0] pick_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return imp_pkg::PRIO_IN_W'($urandom_range(7));
         default: return rnd12();
      endcase
   endfunction

   task automatic send_req(input imp_pkg::req_op_type op,
                           input logic [imp_pkg::KEY_W-1:0] key,
                           input logic [imp_pkg::PRIO_IN_W-1:0] init_p,
                           input logic [imp_pkg::PRIO_IN_W-1:0] inc_p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.req_type          <= op;
      req_chan.key_id            <= key;
      req_chan.initial_priority  <= init_p;
      req_chan.priority_increase <= inc_p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      imp_pkg::req_op_type       op;
      logic [imp_pkg::KEY_W-1:0] key;
      int                        r;
      for (int n = 0; n < count; n++) begin
         r   = $urandom_range(99);
         op  = (r < 35) ? imp_pkg::OP_INSERT : (r < 60) ? imp_pkg::OP_INCREASE :
               (r < 75) ? imp_pkg::OP_REMOVE : imp_pkg::OP_QUERY;
         key = $urandom_range(1) ? imp_pkg::KEY_W'($urandom_range(7)) :
                                   imp_pkg::KEY_W'($urandom_range(63));
         send_req(op, key, pick_level(), pick_level());
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin : ready_gen
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      reset                      <= 1'b1;
      req_chan.valid             <= 1'b0;
      req_chan.req_type          <= imp_pkg::OP_INSERT;
      req_chan.key_id            <= '0;
      req_chan.initial_priority  <= '0;
      req_chan.priority_increase <= '0;
      send_idle_pct              <= 0;
      recv_stall_pct             <= 0;
      hold_seq                   <= 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, ignored keys, ties, re-insert, saturation
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INCREASE, 6'd5,  rnd12(), 12'hFFF);
      send_req(imp_pkg::OP_REMOVE,   6'd7,  rnd12(), rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd63, rnd12(), rnd12());
      send_req(imp_pkg::OP_INSERT,   6'd0,  12'd0,   rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INSERT,   6'd63, 12'hFFF, rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INSERT,   6'd10, 12'hFFF, rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INSERT,   6'd63, 12'hFFF, rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INCREASE, 6'd0,  rnd12(), 12'hFFF);
      send_req(imp_pkg::OP_INCREASE, 6'd0,  rnd12(), 12'd1);
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_INCREASE, 6'd10, rnd12(), 12'd0);
      send_req(imp_pkg::OP_REMOVE,   6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      send_req(imp_pkg::OP_REMOVE,   6'd10, rnd12(), rnd12());
      send_req(imp_pkg::OP_REMOVE,   6'd63, rnd12(), rnd12());
      send_req(imp_pkg::OP_INCREASE, 6'd63, rnd12(), 12'd5);
      send_req(imp_pkg::OP_QUERY,    6'd0,  rnd12(), rnd12());
      settle();

      run_random(200);
      // long result stall: keep offering queries until the input backs up
      hold_seq <= hold_seq + 1;
      repeat (12) send_req(imp_pkg::OP_QUERY, imp_pkg::KEY_W'($urandom_range(63)),
                           rnd12(), rnd12());
      run_random(100);
      settle();

      set_idling(77, 0);
      run_random(400);
      settle();
      set_idling(0, 77);
      run_random(400);
      settle();
      set_idling(37, 37);
      run_random(400);
      settle();

      // equal priorities: earlier arrival wins over the lower key
      set_idling(0, 0);
      for (int k = 0; k < 64; k++)
         send_req(imp_pkg::OP_REMOVE, imp_pkg::KEY_W'(k), rnd12(), rnd12());
      send_req(imp_pkg::OP_INSERT, 6'd40, 12'hFFF, rnd12());
      send_req(imp_pkg::OP_INSERT, 6'd3,  12'hFFF, rnd12());
      send_req(imp_pkg::OP_QUERY,  6'd0,  rnd12(),  rnd12());
      set_idling(37, 37);
      run_random(80);
      settle();

      if (fail_count == 0 && answers_due == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- indexed_max_priority_table.f -----
rtl/imp_pkg.sv
rtl/imp_if.sv
rtl/imp_dp.sv
rtl/imp_ctrl.sv
rtl/indexed_max_priority_table.sv
verif/imp_table_checker.sv
verif/tb_top.sv
